### hdl/nls_pkg.sv
// Package: widths and coefficient table for the natural log series pipeline.
package nls_pkg;

  localparam int unsigned OPERAND_BITS   = 16;
  localparam int unsigned FRAC_BITS      = 30;
  localparam int unsigned DEN_W          = OPERAND_BITS + 1;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = FRAC_BITS / BITS_PER_STAGE;
  localparam int unsigned TERMS          = 7;
  localparam int unsigned HORNER_STAGES  = TERMS - 1;
  localparam int unsigned LOG_W          = 32;
  localparam int unsigned Y_W            = FRAC_BITS + 1;

  // round(2^30 / k), k = 13, 11, 9, 7, 5, 3, 1 (Horner order)
  localparam logic [31:0] HORNER_COEF [TERMS] = '{
    32'd82595525, 32'd97612893, 32'd119304647, 32'd153391689,
    32'd214748365, 32'd357913941, 32'd1073741824
  };

endpackage

### hdl/natural_log_series.sv
// Natural log series: pipelined ln(n) by the seven-term atanh series.
module natural_log_series (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [nls_pkg::OPERAND_BITS-1:0] operand_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [nls_pkg::LOG_W-1:0] log_value_o
);
  // Computes log_value ~ ln(operand) in signed Q3.28 as
  // 2*(x + x^3/3 + ... + x^13/13) with x = (n-1)/(n+1) in Q1.30, no range
  // reduction, so accuracy drops as n grows; n = 0 gives x = -1.
  // Throughput is one operand per cycle while the output is not stalled. The
  // pipe from input to result has one capture stage, 15 restoring divider
  // stages (two quotient bits each), one squaring stage, six Horner stages
  // (one 31x32 multiply each) and the final x*p stage, which is also the
  // output register. The whole pipe advances together whenever the output
  // register is empty or its result is being taken, so stalls drop nothing.
  import nls_pkg::*;

  logic en;

  // divider stages: index 0 captures the operand
  logic                 d_vld_q  [DIV_STAGES+1];
  logic [DEN_W-1:0]     d_den_q  [DIV_STAGES+1];
  logic [DEN_W-1:0]     d_rem_q  [DIV_STAGES+1];
  logic [FRAC_BITS-1:0] d_quo_q  [DIV_STAGES+1];
  logic                 d_zero_q [DIV_STAGES+1];
  logic [DEN_W-1:0]     d_rem_d  [DIV_STAGES+1];
  logic [FRAC_BITS-1:0] d_quo_d  [DIV_STAGES+1];

  // square stage
  logic              s_vld_q;
  logic signed [31:0] s_x_q;
  logic [Y_W-1:0]    s_y_q;
  logic signed [31:0] s_x_d;
  logic signed [63:0] s_sq;

  // Horner stages
  logic               h_vld_q [HORNER_STAGES];
  logic signed [31:0] h_x_q   [HORNER_STAGES];
  logic [Y_W-1:0]     h_y_q   [HORNER_STAGES];
  logic [31:0]        h_p_q   [HORNER_STAGES];
  logic [31:0]        h_p_d   [HORNER_STAGES];

  // output stage
  logic               o_vld_q;
  logic signed [31:0] o_log_q;
  logic signed [63:0] o_prod;

  assign en          = !o_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = o_vld_q;
  assign log_value_o = o_log_q;

  // two restoring division steps per stage
  always_comb begin
    logic [DEN_W-1:0]     r;
    logic [FRAC_BITS-1:0] q;
    logic [DEN_W:0]       t;
    d_rem_d[0] = '0;
    d_quo_d[0] = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      r = d_rem_q[k-1];
      q = d_quo_q[k-1];
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        t = {r, 1'b0};
        if (t >= {1'b0, d_den_q[k-1]}) begin
          t = t - {1'b0, d_den_q[k-1]};
          q = {q[FRAC_BITS-2:0], 1'b1};
        end else begin
          q = {q[FRAC_BITS-2:0], 1'b0};
        end
        r = t[DEN_W-1:0];
      end
      d_rem_d[k] = r;
      d_quo_d[k] = q;
    end
  end

  // x = -1.0 for a zero operand, else the quotient
  assign s_x_d = d_zero_q[DIV_STAGES] ? -32'sd1073741824
                                      : $signed({2'b00, d_quo_q[DIV_STAGES]});
  assign s_sq  = s_x_d * s_x_d;

  always_comb begin
    logic [62:0] m;
    logic [31:0] p_in;
    for (int i = 0; i < HORNER_STAGES; i++) begin
      p_in     = (i == 0) ? HORNER_COEF[0] : h_p_q[(i == 0) ? 0 : i-1];
      m        = (i == 0) ? ({32'd0, s_y_q} * {31'd0, HORNER_COEF[0]})
                          : ({32'd0, h_y_q[(i == 0) ? 0 : i-1]} * {31'd0, p_in});
      h_p_d[i] = HORNER_COEF[i+1] + m[61:30];
    end
  end

  // p < 2^31, so it is safe as a signed operand
  assign o_prod = h_x_q[HORNER_STAGES-1] * $signed(h_p_q[HORNER_STAGES-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STAGES; k++) d_vld_q[k] <= 1'b0;
      s_vld_q <= 1'b0;
      for (int i = 0; i < HORNER_STAGES; i++) h_vld_q[i] <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q[0] <= in_valid_i;
      for (int k = 1; k <= DIV_STAGES; k++) d_vld_q[k] <= d_vld_q[k-1];
      s_vld_q    <= d_vld_q[DIV_STAGES];
      h_vld_q[0] <= s_vld_q;
      for (int i = 1; i < HORNER_STAGES; i++) h_vld_q[i] <= h_vld_q[i-1];
      o_vld_q    <= h_vld_q[HORNER_STAGES-1];
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_den_q[0]  <= {1'b0, operand_i} + DEN_W'(1);
      d_zero_q[0] <= (operand_i == '0);
      d_rem_q[0]  <= (operand_i == '0) ? DEN_W'(1)
                                       : {1'b0, operand_i} - DEN_W'(1);
      d_quo_q[0]  <= '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        d_den_q[k]  <= d_den_q[k-1];
        d_zero_q[k] <= d_zero_q[k-1];
        d_rem_q[k]  <= d_rem_d[k];
        d_quo_q[k]  <= d_quo_d[k];
      end
      s_x_q <= s_x_d;
      s_y_q <= s_sq[60:30];
      h_x_q[0] <= s_x_q;
      h_y_q[0] <= s_y_q;
      h_p_q[0] <= h_p_d[0];
      for (int i = 1; i < HORNER_STAGES; i++) begin
        h_x_q[i] <= h_x_q[i-1];
        h_y_q[i] <= h_y_q[i-1];
        h_p_q[i] <= h_p_d[i];
      end
      o_log_q <= o_prod[62:31];
    end
  end

endmodule

### tb/tb_natural_log_series.sv
// Testbench for natural_log_series: random and directed operands checked against a local model.
module tb_natural_log_series;
  timeunit 1ns;
  timeprecision 1ps;

  import nls_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned STALL_LIMIT  = 20000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [OPERAND_BITS-1:0]        operand_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic signed [LOG_W-1:0]        log_value_o;

  natural_log_series dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operand_i   (operand_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .log_value_o (log_value_o)
  );

  // Operands waiting to be offered, and logs expected back, oldest first.
  logic [OPERAND_BITS-1:0] operand_q[$];
  logic signed [LOG_W-1:0] expected_log_q[$];
  int unsigned             mismatches;
  bit                      hold_off;      // long receiver stall, forces backpressure

  // floor(v / 2^s) for signed v
  function automatic longint floor_div_pow2(input longint v, input int unsigned s);
    return v >>> s;
  endfunction

  // ln(n) by the seven-term atanh series, Q3.28
  function automatic logic signed [LOG_W-1:0] series_log(input logic [OPERAND_BITS-1:0] n);
    longint unsigned den;
    longint unsigned quot;
    longint          x;
    longint          y;
    longint          p;
    den = longint'(n) + 1;
    if (n == 0) begin
      quot = (longint'(1) << FRAC_BITS) / den;
      x    = -longint'(quot);
    end else begin
      quot = ((longint'(n) - 1) << FRAC_BITS) / den;
      x    = longint'(quot);
    end
    // x*x and y*p are nonnegative, so a plain shift floors them
    y = (x * x) >>> FRAC_BITS;
    p = longint'(HORNER_COEF[0]);
    for (int k = 1; k < TERMS; k++) begin
      p = longint'(HORNER_COEF[k]) + ((y * p) >>> FRAC_BITS);
    end
    return LOG_W'(floor_div_pow2(x * p, 31));
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: bursts of transfers separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operand_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_log_q.push_back(series_log(operand_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (operand_q.size() != 0) begin
          in_valid_i <= 1'b1;
          operand_i  <= operand_q.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(40, 1);
            gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus the long hold-off.
  int unsigned stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode  <= 0;
    end else begin
      if ($urandom_range(63, 0) == 0) stall_mode <= $urandom_range(2, 0);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(3, 0) != 0);
          default: out_ready_i <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // Monitor: compare each transfer with the oldest expectation.
  logic signed [LOG_W-1:0] expected_log;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_log_q.size() == 0) begin
        $display("%0t: unexpected log_value %0d", $time, log_value_o);
        mismatches++;
      end else begin
        expected_log = expected_log_q.pop_front();
        if (log_value_o !== expected_log) begin
          $display("%0t: log_value expected %0d actual %0d", $time, expected_log, log_value_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either side.
  int unsigned idle_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    hold_off = 1;
    // Directed: zero and unit operands, field extremes, single bits.
    operand_q.push_back(OPERAND_BITS'(0));
    operand_q.push_back(OPERAND_BITS'(1));
    operand_q.push_back(OPERAND_BITS'(2));
    operand_q.push_back(OPERAND_BITS'(3));
    operand_q.push_back(16'hFFFF);
    operand_q.push_back(16'hFFFE);
    operand_q.push_back(16'h8000);
    operand_q.push_back(16'h7FFF);
    operand_q.push_back(16'h5555);
    operand_q.push_back(16'hAAAA);
    for (int b = 2; b < OPERAND_BITS; b += 2) operand_q.push_back(16'(1) << b);
    // Random: half small operands where the series is accurate, half over the full range.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(3, 0))
        0:       operand_q.push_back(OPERAND_BITS'($urandom_range(16, 0)));
        1:       operand_q.push_back(OPERAND_BITS'($urandom_range(1024, 0)));
        default: operand_q.push_back(OPERAND_BITS'($urandom_range(16'hFFFF, 0)));
      endcase
    end
    // Long receiver hold-off at the start while the sender keeps offering.
    @(posedge rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off = 0;
    wait (operand_q.size() == 0 && !in_valid_i);
    wait (expected_log_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_log_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
hdl/nls_pkg.sv
hdl/natural_log_series.sv
tb/tb_natural_log_series.sv
